@@ hdl/sva_pkg.sv @@
// Shared types, constants and layer selection for the sampler voice allocator.
package sva_pkg;

   // Default sizes of the voice table
   localparam int VOICES_DEF   = 16;
   localparam int LAYERS_DEF   = 4;
   localparam int AGE_BITS_DEF = 32;

   // Register reset values
   localparam logic [6:0]  MIN_PITCH_RESET   = 7'd21;
   localparam logic [6:0]  MAX_PITCH_RESET   = 7'd108;
   localparam logic [2:0]  LAYER_COUNT_RESET = 3'd1;
   localparam logic [27:0] LAYER_TOPS_RESET  = 28'd127;

   // Threshold for layers past the fourth
   localparam logic [6:0]  TOP_DEFAULT = 7'd127;

   typedef enum logic [1:0] {
      KIND_NOTE_ON   = 2'd0,
      KIND_NOTE_OFF  = 2'd1,
      KIND_ALL_OFF   = 2'd2,
      KIND_VOICE_END = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      CSR_LOADED      = 3'd0,
      CSR_MIN_PITCH   = 3'd1,
      CSR_MAX_PITCH   = 3'd2,
      CSR_LAYER_COUNT = 3'd3,
      CSR_LAYER_TOPS  = 3'd4,
      CSR_PERCUSSIVE  = 3'd5,
      CSR_INSTANT     = 3'd6
   } csr_index_type;

   typedef struct packed {
      kind_type   kind;
      logic [6:0] note;
      logic [6:0] velocity;
      logic       sample_present;
      logic [3:0] done_voice;
   } req_type;

   typedef struct packed {
      logic        started;
      logic        stolen;
      logic [3:0]  voice;
      logic [1:0]  layer;
      logic [15:0] released_mask;
      logic [15:0] stopped_mask;
   } rsp_type;

   // Flags of one voice as it passes the pick unit during a scan
   typedef struct packed {
      logic valid;
      logic active;
      logic releasing;
   } step_type;

   // First layer whose threshold is at or above the velocity, else the last one in use
   function automatic logic [2:0] pick_layer(input logic [2:0]  count,
                                             input logic [27:0] tops,
                                             input logic [6:0]  vel,
                                             input int          layers);
      logic [3:0] n;
      logic [2:0] res;
      logic       found;
      logic [6:0] top;
      if (count == 3'd0) begin
         n = 4'd1;
      end else if (int'(count) > layers) begin
         n = 4'(layers);
      end else begin
         n = {1'b0, count};
      end
      res   = 3'(n - 4'd1);
      found = 1'b0;
      for (int i = 0; i < 8; i++) begin
         top = (i < 4) ? tops[7*i +: 7] : TOP_DEFAULT;
         if (!found && (4'(i) < n) && (vel <= top)) begin
            res   = 3'(i);
            found = 1'b1;
         end
      end
      return res;
   endfunction

endpackage

@@ hdl/sva_voice_store.sv @@
// Per-voice note and age store, one write port and one registered read port.
module sva_voice_store import sva_pkg::*; #(
   parameter int VOICES   = VOICES_DEF,
   parameter int AGE_BITS = AGE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(VOICES)-1:0] wr_addr,
   input  logic [6:0]                wr_note,
   input  logic [AGE_BITS-1:0]       wr_age,
   input  logic                      rd_en,
   input  logic [$clog2(VOICES)-1:0] rd_addr,
   output logic [6:0]                rd_note,
   output logic [AGE_BITS-1:0]       rd_age
);

   localparam int ENTRY_W = 7 + AGE_BITS;

   logic [ENTRY_W-1:0] mem_ff [VOICES];
   logic [ENTRY_W-1:0] rd_data_ff;

   // Write a started voice
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= {wr_note, wr_age};
      end
   end

   // Read one voice per cycle during a scan
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_note = rd_data_ff[ENTRY_W-1 -: 7];
   assign rd_age  = rd_data_ff[AGE_BITS-1:0];

endmodule

@@ hdl/sva_pick_unit.sv @@
// Voice pick unit: first free voice; one shared age comparator for oldest releasing and held.
module sva_pick_unit import sva_pkg::*; #(
   parameter int VOICES   = VOICES_DEF,
   parameter int AGE_BITS = AGE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  step_type                  step,
   input  logic [$clog2(VOICES)-1:0] step_idx,
   input  logic [AGE_BITS-1:0]       step_age,
   output logic [$clog2(VOICES)-1:0] pick_idx,
   output logic                      pick_stolen
);

   localparam int IDX_W = $clog2(VOICES);

   logic                free_found_ff, free_found_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic                rel_found_ff, rel_found_in;
   logic [IDX_W-1:0]    rel_idx_ff, rel_idx_in;
   logic [AGE_BITS-1:0] rel_age_ff, rel_age_in;
   logic                held_found_ff, held_found_in;
   logic [IDX_W-1:0]    held_idx_ff, held_idx_in;
   logic [AGE_BITS-1:0] held_age_ff, held_age_in;

   logic [AGE_BITS-1:0] cmp_age;
   logic                cmp_found;
   logic                older;

   // Shared compare against the best candidate of the voice's own class
   assign cmp_age   = step.releasing ? rel_age_ff : held_age_ff;
   assign cmp_found = step.releasing ? rel_found_ff : held_found_ff;
   assign older     = !cmp_found || (step_age < cmp_age);

   // Update candidates; ties keep the lower index
   always_comb begin
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rel_found_in  = rel_found_ff;
      rel_idx_in    = rel_idx_ff;
      rel_age_in    = rel_age_ff;
      held_found_in = held_found_ff;
      held_idx_in   = held_idx_ff;
      held_age_in   = held_age_ff;
      if (clear) begin
         free_found_in = 1'b0;
         rel_found_in  = 1'b0;
         held_found_in = 1'b0;
      end else if (step.valid) begin
         if (!step.active) begin
            if (!free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = step_idx;
            end
         end else if (older) begin
            if (step.releasing) begin
               rel_found_in = 1'b1;
               rel_idx_in   = step_idx;
               rel_age_in   = step_age;
            end else begin
               held_found_in = 1'b1;
               held_idx_in   = step_idx;
               held_age_in   = step_age;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_found_ff <= 1'b0;
         rel_found_ff  <= 1'b0;
         held_found_ff <= 1'b0;
      end else begin
         free_found_ff <= free_found_in;
         rel_found_ff  <= rel_found_in;
         held_found_ff <= held_found_in;
      end
      free_idx_ff <= free_idx_in;
      rel_idx_ff  <= rel_idx_in;
      rel_age_ff  <= rel_age_in;
      held_idx_ff <= held_idx_in;
      held_age_ff <= held_age_in;
   end

   // Free voice first, then oldest releasing, then oldest held
   always_comb begin
      priority if (free_found_ff) begin
         pick_idx = free_idx_ff;
      end else if (rel_found_ff) begin
         pick_idx = rel_idx_ff;
      end else begin
         pick_idx = held_idx_ff;
      end
   end

   assign pick_stolen = !free_found_ff;

endmodule

@@ hdl/sampler_voice_allocator.sv @@
// Sampler voice allocator top level: registers, voice flags and the scan sequencer.
//
//   channel | ports                             | handshake
//   --------+-----------------------------------+-------------------------------
//   request | start, busy, req_data             | taken when start && !busy
//   result  | rsp_strobe, rsp_data              | one-cycle strobe, no backpressure
//   config  | csr_valid, csr_ready, csr_index,  | written when csr_valid && csr_ready
//           | csr_wdata                         |
//
// A note-on or note-off that needs the table scans every voice before it strobes its result:
// the voice store has one read port and the scan reads one voice per cycle, followed by the
// drain state, the commit state and the registered strobe. Other requests skip the scan and
// the drain state and go straight to the commit state and the registered strobe.
// busy is high from the cycle after start until the strobe. Reset is synchronous and
// clears the voice flags, age counter and registers; no clearing pass.
module sampler_voice_allocator import sva_pkg::*; #(
   parameter int VOICES   = VOICES_DEF,
   parameter int LAYERS   = LAYERS_DEF,
   parameter int AGE_BITS = AGE_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_data,
   output logic          rsp_strobe,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [27:0]   csr_wdata
);

   localparam int IDX_W = $clog2(VOICES);
   localparam int PAD_V = (VOICES > 16) ? VOICES : 16;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic        loaded_ff;
   logic [6:0]  min_pitch_ff;
   logic [6:0]  max_pitch_ff;
   logic [2:0]  layer_count_ff;
   logic [27:0] layer_tops_ff;
   logic        percussive_ff;
   logic        instant_ff;

   // Latched request
   kind_type    kind_ff;
   logic        enabled_ff;
   logic        on_ok_ff;
   logic [6:0]  note_ff;
   logic [6:0]  vel_ff;
   logic [3:0]  done_ff;

   // Voice table flags and age counter
   logic [VOICES-1:0]   active_ff, active_in;
   logic [VOICES-1:0]   releasing_ff, releasing_in;
   logic [AGE_BITS-1:0] age_ff;

   // Scan pipeline
   logic [IDX_W-1:0] addr_ff;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] proc_idx_ff;
   logic [15:0]      rmask_ff, rmask_in;
   logic [15:0]      smask_ff, smask_in;

   logic             rsp_strobe_ff;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic                accept;
   kind_type            kind_eff;
   logic                enabled_now;
   logic                on_ok_now;
   logic                need_scan;
   logic [6:0]          rd_note;
   logic [AGE_BITS-1:0] rd_age;
   step_type            step;
   logic [IDX_W-1:0]    pick_idx;
   logic                pick_stolen;
   logic                proc_active;
   logic                proc_releasing;
   logic                proc_hit;
   logic [PAD_V-1:0]    proc_onehot;
   logic [PAD_V-1:0]    done_onehot;
   logic [PAD_V-1:0]    active_pad;
   logic [IDX_W+3:0]    done_wide;
   logic [IDX_W+3:0]    pick_wide;
   logic                done_ok;
   logic                commit_on;
   logic [2:0]          layer_sel;

   assign accept      = start && !busy;
   assign busy        = (state_ff != ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_data    = rsp_data_ff;

   // Decode the request: velocity zero turns a note-on into a note-off
   assign kind_eff    = (req_data.kind == KIND_NOTE_ON && req_data.velocity == 7'd0) ?
                        KIND_NOTE_OFF : req_data.kind;
   assign enabled_now = loaded_ff && (max_pitch_ff >= min_pitch_ff);
   assign on_ok_now   = (req_data.note >= min_pitch_ff) && (req_data.note <= max_pitch_ff) &&
                        req_data.sample_present;
   assign need_scan   = enabled_now &&
                        ((kind_eff == KIND_NOTE_ON && on_ok_now) ||
                         (kind_eff == KIND_NOTE_OFF && !percussive_ff));

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff      <= 1'b0;
         min_pitch_ff   <= MIN_PITCH_RESET;
         max_pitch_ff   <= MAX_PITCH_RESET;
         layer_count_ff <= LAYER_COUNT_RESET;
         layer_tops_ff  <= LAYER_TOPS_RESET;
         percussive_ff  <= 1'b0;
         instant_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LOADED:      loaded_ff      <= csr_wdata[0];
            CSR_MIN_PITCH:   min_pitch_ff   <= csr_wdata[6:0];
            CSR_MAX_PITCH:   max_pitch_ff   <= csr_wdata[6:0];
            CSR_LAYER_COUNT: layer_count_ff <= csr_wdata[2:0];
            CSR_LAYER_TOPS:  layer_tops_ff  <= csr_wdata;
            CSR_PERCUSSIVE:  percussive_ff  <= csr_wdata[0];
            CSR_INSTANT:     instant_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = need_scan ? ST_SCAN : ST_COMMIT;
         ST_SCAN:   if (addr_ff == LAST_IDX) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= (state_ff == ST_SCAN);
      end
      if (accept) begin
         addr_ff <= '0;
      end else if (state_ff == ST_SCAN) begin
         addr_ff <= addr_ff + IDX_W'(1);
      end
      proc_idx_ff <= addr_ff;
   end

   // Hold the request for the duration of its work
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= KIND_NOTE_ON;
         enabled_ff <= 1'b0;
         on_ok_ff   <= 1'b0;
      end else if (accept) begin
         kind_ff    <= kind_eff;
         enabled_ff <= enabled_now;
         on_ok_ff   <= on_ok_now;
      end
      if (accept) begin
         note_ff <= req_data.note;
         vel_ff  <= req_data.velocity;
         done_ff <= req_data.done_voice;
      end
   end

   sva_voice_store #(
      .VOICES   (VOICES),
      .AGE_BITS (AGE_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (commit_on),
      .wr_addr (pick_idx),
      .wr_note (note_ff),
      .wr_age  (age_ff),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (addr_ff),
      .rd_note (rd_note),
      .rd_age  (rd_age)
   );

   // Flags of the voice whose store data just arrived
   assign proc_active    = active_ff[proc_idx_ff];
   assign proc_releasing = releasing_ff[proc_idx_ff];
   assign step.valid     = rd_vld_ff && (kind_ff == KIND_NOTE_ON);
   assign step.active    = proc_active;
   assign step.releasing = proc_releasing;

   sva_pick_unit #(
      .VOICES   (VOICES),
      .AGE_BITS (AGE_BITS)
   ) u_pick (
      .clock       (clock),
      .reset       (reset),
      .clear       (accept),
      .step        (step),
      .step_idx    (proc_idx_ff),
      .step_age    (rd_age),
      .pick_idx    (pick_idx),
      .pick_stolen (pick_stolen)
   );

   assign proc_hit    = rd_vld_ff && (kind_ff == KIND_NOTE_OFF) && proc_active &&
                        !proc_releasing && (rd_note == note_ff);
   assign proc_onehot = PAD_V'(1) << proc_idx_ff;
   assign done_wide   = (IDX_W+4)'(done_ff);
   assign done_ok     = (32'(done_ff) < 32'(VOICES)) && active_ff[done_wide[IDX_W-1:0]];
   assign done_onehot = PAD_V'(1) << done_wide[IDX_W-1:0];
   assign active_pad  = PAD_V'(active_ff);
   assign pick_wide   = (IDX_W+4)'(pick_idx);
   assign commit_on   = (state_ff == ST_COMMIT) && enabled_ff && (kind_ff == KIND_NOTE_ON) &&
                        on_ok_ff;
   assign layer_sel   = pick_layer(layer_count_ff, layer_tops_ff, vel_ff, LAYERS);

   // Voice flag updates, release masks and the result
   always_comb begin
      active_in    = active_ff;
      releasing_in = releasing_ff;
      rmask_in     = rmask_ff;
      smask_in     = smask_ff;
      rsp_data_in  = '0;
      if (accept) begin
         rmask_in = '0;
         smask_in = '0;
      end
      // Release held voices of the note as the scan passes them
      if (proc_hit) begin
         releasing_in[proc_idx_ff] = 1'b1;
         rmask_in = rmask_ff | proc_onehot[15:0];
         if (instant_ff) begin
            active_in[proc_idx_ff] = 1'b0;
            smask_in = smask_ff | proc_onehot[15:0];
         end
      end
      if (state_ff == ST_COMMIT && enabled_ff) begin
         unique case (kind_ff)
            KIND_NOTE_ON: begin
               if (on_ok_ff) begin
                  active_in[pick_idx]    = 1'b1;
                  releasing_in[pick_idx] = 1'b0;
                  rsp_data_in.started    = 1'b1;
                  rsp_data_in.stolen     = pick_stolen;
                  rsp_data_in.voice      = pick_wide[3:0];
                  rsp_data_in.layer      = layer_sel[1:0];
               end
            end
            KIND_NOTE_OFF: begin
               rsp_data_in.released_mask = rmask_ff;
               rsp_data_in.stopped_mask  = smask_ff;
            end
            KIND_ALL_OFF: begin
               active_in                = '0;
               rsp_data_in.stopped_mask = active_pad[15:0];
            end
            KIND_VOICE_END: begin
               if (done_ok) begin
                  active_in[done_wide[IDX_W-1:0]] = 1'b0;
                  rsp_data_in.stopped_mask        = done_onehot[15:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         releasing_ff  <= '0;
         age_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         active_ff     <= active_in;
         releasing_ff  <= releasing_in;
         rsp_strobe_ff <= (state_ff == ST_COMMIT);
         // Advance the age stamp, saturating at all ones
         if (commit_on && (age_ff != {AGE_BITS{1'b1}})) begin
            age_ff <= age_ff + AGE_BITS'(1);
         end
      end
      rmask_ff    <= rmask_in;
      smask_ff    <= smask_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ hdl/sva_checker.sv @@
// Port-level checks for the sampler voice allocator, bound to the top level.
module sva_checker import sva_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // Each request yields one strobe, never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // A taken request makes the block busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after a request was taken");

   // Work ends with a result
   a_result_at_end: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_strobe)
      else $error("busy dropped without a result");

   // Voice fields are zero unless a voice started
   a_idle_voice_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.started) |->
         (!rsp_data.stolen && rsp_data.voice == 4'd0 && rsp_data.layer == 2'd0))
      else $error("voice fields set without a start");

   // A note start releases and stops nothing
   a_start_no_masks: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.started) |->
         (rsp_data.released_mask == 16'd0 && rsp_data.stopped_mask == 16'd0))
      else $error("masks set on a started voice");

endmodule

bind sampler_voice_allocator sva_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
